// ===== sv/wdrc_compressor_top_macros.svh =====
// Assertion macros shared by the compressor checker.
`ifndef WDRC_COMPRESSOR_TOP_MACROS_SVH
`define WDRC_COMPRESSOR_TOP_MACROS_SVH

// Implication in the same cycle, disabled while reset is high.
`define WDRC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication on the next cycle, disabled while reset is high.
`define WDRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication on the next cycle that also holds across reset.
`define WDRC_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/wdrc_pkg.sv =====
// Types, constants and constant functions of the compressor.
`default_nettype none
package wdrc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int PEAK_W      = 32;
   localparam int DB_W        = 16;
   localparam int COEF_W      = 16;
   localparam int RATIO_W     = 12;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CURVE_W     = 40;
   localparam int DIV_NUM_W   = 32;
   localparam int DIV_DEN_W   = 12;
   localparam int LOG_STEPS   = 16;
   localparam int EXP_STEPS   = 16;

   localparam logic [CSR_IDX_W-1:0] REG_ATTACK_COEF    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_COEF   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KNEE_GAIN_DB   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KNEE_LEVEL_DB  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COMP_RATIO     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_LEVEL_DB = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE_DB  = 3'd6;

   localparam logic [COEF_W-1:0]  RST_ATTACK_COEF    = 16'd65000;
   localparam logic [COEF_W-1:0]  RST_RELEASE_COEF   = 16'd65500;
   localparam logic [DB_W-1:0]    RST_KNEE_GAIN_DB   = 16'd0;
   localparam logic [DB_W-1:0]    RST_KNEE_LEVEL_DB  = 16'd12800;
   localparam logic [RATIO_W-1:0] RST_COMP_RATIO     = 12'd512;
   localparam logic [DB_W-1:0]    RST_LIMIT_LEVEL_DB = 16'd23040;
   localparam logic [DB_W-1:0]    RST_FULL_SCALE_DB  = 16'd30464;

   // 20*log10(2) in Q16 and log2(10)/20 in Q24.
   localparam logic [31:0] DB_PER_OCT_Q16 = 32'd394566;
   localparam logic [31:0] OCT_PER_DB_Q24 = 32'd2786635;
   localparam logic [31:0] Q30_ONE        = 32'h4000_0000;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          block_end;
   } req_data_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic signed [DB_W-1:0]        gain_db;
      logic                          block_end_out;
   } rsp_data_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PK_MUL1,
      S_PK_MUL2,
      S_PK_SUM,
      S_LOG_NORM,
      S_LOG_MUL,
      S_LOG_STEP,
      S_ATT_MUL,
      S_ATT_SUB,
      S_CRV_START,
      S_DIV_TK,
      S_PBLT_MUL,
      S_PBLT,
      S_SEL,
      S_DIV_LIM,
      S_DIV_SLOPE,
      S_EXP_MUL,
      S_EXP_SPLIT,
      S_EXP_STEP_MUL,
      S_EXP_STEP,
      S_APPLY_MUL,
      S_ROUND,
      S_OUT
   } state_type;

   typedef logic [EXP_STEPS-1:0][31:0] exp2_tab_type;

   // Truncating integer square root, evaluated at elaboration only.
   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      n = n_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (b > n) begin
            b = b >> 2;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // Entry k holds 2^(2^-(k+1)) in Q30, each root taken from the one before.
   function automatic exp2_tab_type exp2_table();
      exp2_tab_type tab;
      logic [63:0]  c;
      c = isqrt64(64'd2 << 60);
      for (int k = 0; k < EXP_STEPS; k++) begin
         tab[k] = c[31:0];
         c = isqrt64(c << 30);
      end
      return tab;
   endfunction

   localparam exp2_tab_type EXP2_TAB = exp2_table();

   function automatic logic signed [DB_W-1:0] sat16(input logic signed [CURVE_W-1:0] v);
      logic signed [DB_W-1:0] res;
      if (v > 32767) begin
         res = 16'sh7fff;
      end else if (v < -32768) begin
         res = 16'sh8000;
      end else begin
         res = v[DB_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [CURVE_W-1:0] abs40(input logic signed [CURVE_W-1:0] v);
      logic [CURVE_W-1:0] res;
      if (v < 0) begin
         res = CURVE_W'(-v);
      end else begin
         res = CURVE_W'(v);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== sv/wdrc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module wdrc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  wdrc_pkg::div_req_type div_req,
   output wdrc_pkg::div_rsp_type div_rsp
);
   import wdrc_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[DIV_NUM_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = div_req.den;
         quo_in  = div_req.num;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so the trial fits one extra bit.
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule
`default_nettype wire

// ===== sv/wdrc_compressor_top.sv =====
// Top level of the wide dynamic range compressor: sequencer, shared multiplier, registers.
//
//   channel   ports                            direction  transfer
//   request   req_valid req_ready req_data     in         valid/ready, one sample
//   response  rsp_valid rsp_ready rsp_data     out        valid/ready, one sample
//   config    csr_we csr_index csr_wdata       in         write on csr_we, no wait
//
// One sample holds the block from acceptance to the next acceptance. A zero peak skips log2
// and attenuation. The single 32x32 multiplier serves the peak follower, 16 log2 squarings,
// the attenuation, the limit line, the dB-to-octave scaling, 16 exp2 steps, the gain and the
// division by ten; the one-bit-per-cycle divider serves the knee and the slope-segment gain.
// Reset is synchronous and clears the sequencer, the peak and the registers.
// A finished result waits in the output register, and the next sample may be taken.
`default_nettype none
module wdrc_compressor_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  wdrc_pkg::req_data_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output wdrc_pkg::rsp_data_type             rsp_data,
   input  logic                               csr_we,
   input  logic [wdrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wdrc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import wdrc_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam logic [20:0] LOG_TOP = 21'(31 << 16);
   localparam logic [CURVE_W-1:0] U_BIAS = CURVE_W'(64'd1 << 38);
   // floor(n / 10) equals (n * RECIP_10) >> 35 for any 32-bit n.
   localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

   // Configuration registers.
   logic [COEF_W-1:0]         attack_ff, release_ff;
   logic signed [DB_W-1:0]    knee_gain_ff, knee_level_ff, limit_ff, full_scale_ff;
   logic [RATIO_W-1:0]        ratio_ff;

   state_type                 state_ff, state_in;
   logic [SB-1:0]             ax_ff, ax_in;
   logic                      sneg_ff, sneg_in;
   logic                      be_ff, be_in;
   logic [PEAK_W-1:0]         pk_ff, pk_in;
   logic                      atk_ff, atk_in;
   logic [47:0]               acc_ff, acc_in;
   logic [63:0]               prod_ff, prod_in;
   logic [31:0]               mul_a, mul_b;
   logic [4:0]                msb_ff, msb_in;
   logic [31:0]               m_ff, m_in;
   logic [15:0]               frac_ff, frac_in;
   logic [3:0]                cnt_ff, cnt_in;
   logic signed [DB_W-1:0]    pdb_ff, pdb_in;
   logic signed [17:0]        tk_ff, tk_in;
   logic [RATIO_W-1:0]        crv_ff, crv_in;
   logic                      dsign_ff, dsign_in;
   logic signed [27:0]        tkgo_ff, tkgo_in;
   logic signed [31:0]        pblt_ff, pblt_in;
   logic signed [DB_W-1:0]    gdb_ff, gdb_in;
   logic [5:0]                s_ff, s_in;
   logic [15:0]               f_ff, f_in;
   logic [31:0]               p_ff, p_in;
   logic signed [SB-1:0]      y_ff, y_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_data_type              rsp_data_ff, rsp_data_in;

   div_req_type               div_req;
   div_rsp_type               div_rsp;

   // Helper values.
   logic [PEAK_W-1:0]         xab;
   logic [4:0]                msb_pk;
   logic [48:0]               pk_sum;
   logic [32:0]               sq;
   logic [20:0]               log_l;
   logic [47:0]               att_t;
   logic signed [CURVE_W-1:0] kgn_w, tk0_w, bolt_w, fs_w, tk_w, pdb_w;
   logic signed [CURVE_W-1:0] tkgo_w, pblt_w, tkc_w, qs_w, v_w, q10_w;
   logic [CURVE_W-1:0]        mag_w;
   logic [45:0]               pr_t;
   logic [CURVE_W-1:0]        u_w;
   logic [7:0]                shift_w;
   logic [63:0]               rnd, rsum, r_w, rsat, half;

   wdrc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff     <= RST_ATTACK_COEF;
         release_ff    <= RST_RELEASE_COEF;
         knee_gain_ff  <= RST_KNEE_GAIN_DB;
         knee_level_ff <= RST_KNEE_LEVEL_DB;
         ratio_ff      <= RST_COMP_RATIO;
         limit_ff      <= RST_LIMIT_LEVEL_DB;
         full_scale_ff <= RST_FULL_SCALE_DB;
      end else if (csr_we) begin
         case (csr_index)
            REG_ATTACK_COEF:    attack_ff     <= csr_wdata;
            REG_RELEASE_COEF:   release_ff    <= csr_wdata;
            REG_KNEE_GAIN_DB:   knee_gain_ff  <= csr_wdata;
            REG_KNEE_LEVEL_DB:  knee_level_ff <= csr_wdata;
            REG_COMP_RATIO:     ratio_ff      <= csr_wdata[RATIO_W-1:0];
            REG_LIMIT_LEVEL_DB: limit_ff      <= csr_wdata;
            REG_FULL_SCALE_DB:  full_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      xab    = PEAK_W'(ax_ff) << (PEAK_W - SB);
      msb_pk = '0;
      for (int i = 0; i < PEAK_W; i++) begin
         if (pk_ff[i]) begin
            msb_pk = 5'(i);
         end
      end
      pk_sum = {1'b0, acc_ff} + prod_ff[48:0];
      sq     = {1'b0, prod_ff[61:30]};
      log_l  = {msb_ff, frac_ff};
      att_t  = prod_ff[47:0] + 48'(1 << 23);
      kgn_w  = CURVE_W'(knee_gain_ff);
      tk0_w  = CURVE_W'(knee_level_ff);
      bolt_w = CURVE_W'(limit_ff);
      fs_w   = CURVE_W'(full_scale_ff);
      tk_w   = CURVE_W'(tk_ff);
      pdb_w  = CURVE_W'(pdb_ff);
      tkgo_w = CURVE_W'(tkgo_ff);
      pblt_w = CURVE_W'(pblt_ff);
      // The knee comes down so that knee plus knee gain stays at or below the bolt.
      if (tk0_w + kgn_w > bolt_w) begin
         tkc_w = bolt_w - kgn_w;
      end else begin
         tkc_w = tk0_w;
      end
      if (dsign_ff) begin
         qs_w = -CURVE_W'(div_rsp.quo);
      end else begin
         qs_w = CURVE_W'(div_rsp.quo);
      end
      q10_w = $signed(CURVE_W'(prod_ff[63:35]));
      v_w   = bolt_w - tkgo_w;
      mag_w = abs40(v_w);
      pr_t  = prod_ff[45:0] + 46'd128;
      if (gdb_ff < 0) begin
         u_w = U_BIAS - CURVE_W'(prod_ff[38:0]);
      end else begin
         u_w = U_BIAS + CURVE_W'(prod_ff[38:0]);
      end
      // Right shift for the output is 30 minus the integer octave count.
      shift_w = 8'd94 - u_w[39:32];
      rnd     = 64'd1 << (s_ff - 6'd1);
      rsum    = prod_ff + rnd;
      r_w     = rsum >> s_ff;
      half    = 64'd1 << (SB - 1);
      if (sneg_ff) begin
         rsat = (r_w > half) ? half : r_w;
      end else begin
         rsat = (r_w > half - 64'd1) ? half - 64'd1 : r_w;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      sneg_in      = sneg_ff;
      be_in        = be_ff;
      pk_in        = pk_ff;
      atk_in       = atk_ff;
      acc_in       = acc_ff;
      msb_in       = msb_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      pdb_in       = pdb_ff;
      tk_in        = tk_ff;
      crv_in       = crv_ff;
      dsign_in     = dsign_ff;
      tkgo_in      = tkgo_ff;
      pblt_in      = pblt_ff;
      gdb_in       = gdb_ff;
      s_in         = s_ff;
      f_in         = f_ff;
      p_in         = p_ff;
      y_in         = y_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sneg_in  = req_data.sample_in[SB-1];
               ax_in    = req_data.sample_in[SB-1] ? SB'(-req_data.sample_in)
                                                   : SB'(req_data.sample_in);
               be_in    = req_data.block_end;
               state_in = S_PK_MUL1;
            end
         end
         S_PK_MUL1: begin
            atk_in   = xab >= pk_ff;
            mul_a    = pk_ff;
            mul_b    = (xab >= pk_ff) ? 32'(attack_ff) : 32'(release_ff);
            state_in = S_PK_MUL2;
         end
         S_PK_MUL2: begin
            acc_in   = prod_ff[47:0];
            mul_a    = xab;
            // Release has no second term, so the multiplier gets zero.
            mul_b    = atk_ff ? (32'd65536 - 32'(attack_ff)) : 32'd0;
            state_in = S_PK_SUM;
         end
         S_PK_SUM: begin
            pk_in    = pk_sum[47:16];
            state_in = S_LOG_NORM;
         end
         S_LOG_NORM: begin
            if (pk_ff == '0) begin
               pdb_in   = 16'sh8000;
               state_in = S_CRV_START;
            end else begin
               msb_in  = msb_pk;
               m_in    = (msb_pk == 5'd31) ? (pk_ff >> 1) : (pk_ff << (5'd30 - msb_pk));
               frac_in = '0;
               cnt_in  = '0;
               state_in = S_LOG_MUL;
            end
         end
         S_LOG_MUL: begin
            mul_a    = m_ff;
            mul_b    = m_ff;
            state_in = S_LOG_STEP;
         end
         S_LOG_STEP: begin
            if (sq[31]) begin
               frac_in = {frac_ff[14:0], 1'b1};
               m_in    = sq[32:1];
            end else begin
               frac_in = {frac_ff[14:0], 1'b0};
               m_in    = sq[31:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'(LOG_STEPS - 1)) begin
               state_in = S_ATT_MUL;
            end else begin
               state_in = S_LOG_MUL;
            end
         end
         S_ATT_MUL: begin
            mul_a    = (log_l >= LOG_TOP) ? 32'd0 : 32'(LOG_TOP - log_l);
            mul_b    = DB_PER_OCT_Q16;
            state_in = S_ATT_SUB;
         end
         S_ATT_SUB: begin
            pdb_in   = sat16(fs_w - CURVE_W'(att_t[47:24]));
            state_in = S_CRV_START;
         end
         S_CRV_START: begin
            crv_in        = (ratio_ff == '0) ? RATIO_W'(1) : ratio_ff;
            tk_in         = tkc_w[17:0];
            dsign_in      = tkc_w < 0;
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(abs40(tkc_w) << 8)
                          + DIV_NUM_W'(((ratio_ff == '0) ? RATIO_W'(1) : ratio_ff) >> 1);
            div_req.den   = (ratio_ff == '0) ? RATIO_W'(1) : ratio_ff;
            state_in      = S_DIV_TK;
         end
         S_DIV_TK: begin
            if (div_rsp.done) begin
               tkgo_in  = 28'(kgn_w + tk_w - qs_w);
               state_in = S_PBLT_MUL;
            end
         end
         S_PBLT_MUL: begin
            mul_a    = mag_w[31:0];
            mul_b    = 32'(crv_ff);
            dsign_in = v_w < 0;
            state_in = S_PBLT;
         end
         S_PBLT: begin
            if (dsign_ff) begin
               pblt_in = -32'(pr_t[45:8]);
            end else begin
               pblt_in = 32'(pr_t[45:8]);
            end
            state_in = S_SEL;
         end
         S_SEL: begin
            if (pdb_w < tk_w && ratio_ff >= RATIO_W'(256)) begin
               gdb_in   = knee_gain_ff;
               state_in = S_EXP_MUL;
            end else if (pdb_w > pblt_w) begin
               // The rounded division by ten is a reciprocal product on the shared multiplier.
               mul_a    = 32'(pdb_w - pblt_w) + 32'd5;
               mul_b    = RECIP_10;
               state_in = S_DIV_LIM;
            end else begin
               dsign_in      = pdb_w < 0;
               div_req.start = 1'b1;
               div_req.num   = DIV_NUM_W'(abs40(pdb_w) << 8) + DIV_NUM_W'(crv_ff >> 1);
               div_req.den   = crv_ff;
               state_in      = S_DIV_SLOPE;
            end
         end
         S_DIV_LIM: begin
            gdb_in   = sat16(bolt_w + q10_w - pdb_w);
            state_in = S_EXP_MUL;
         end
         S_DIV_SLOPE: begin
            if (div_rsp.done) begin
               gdb_in   = sat16(qs_w - pdb_w + tkgo_w);
               state_in = S_EXP_MUL;
            end
         end
         S_EXP_MUL: begin
            mul_a    = 32'(abs40(CURVE_W'(gdb_ff)));
            mul_b    = OCT_PER_DB_Q24;
            state_in = S_EXP_SPLIT;
         end
         S_EXP_SPLIT: begin
            s_in     = shift_w[5:0];
            f_in     = u_w[31:16];
            p_in     = Q30_ONE;
            cnt_in   = '0;
            state_in = S_EXP_STEP_MUL;
         end
         S_EXP_STEP_MUL: begin
            // A clear fraction bit multiplies by one in Q30, which leaves p exact.
            mul_a    = p_ff;
            mul_b    = f_ff[15] ? EXP2_TAB[cnt_ff] : Q30_ONE;
            state_in = S_EXP_STEP;
         end
         S_EXP_STEP: begin
            p_in   = prod_ff[61:30];
            f_in   = {f_ff[14:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'(EXP_STEPS - 1)) begin
               state_in = S_APPLY_MUL;
            end else begin
               state_in = S_EXP_STEP_MUL;
            end
         end
         S_APPLY_MUL: begin
            mul_a    = 32'(ax_ff);
            mul_b    = p_ff;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            y_in     = sneg_ff ? SB'(~rsat[SB-1:0] + 1'b1) : SB'(rsat[SB-1:0]);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.sample_out    = y_ff;
               rsp_data_in.gain_db       = gdb_ff;
               rsp_data_in.block_end_out = be_ff;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      prod_in = 64'(mul_a) * 64'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pk_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         pk_ff        <= pk_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      ax_ff       <= ax_in;
      sneg_ff     <= sneg_in;
      be_ff       <= be_in;
      atk_ff      <= atk_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      msb_ff      <= msb_in;
      m_ff        <= m_in;
      frac_ff     <= frac_in;
      pdb_ff      <= pdb_in;
      tk_ff       <= tk_in;
      crv_ff      <= crv_in;
      dsign_ff    <= dsign_in;
      tkgo_ff     <= tkgo_in;
      pblt_ff     <= pblt_in;
      gdb_ff      <= gdb_in;
      s_ff        <= s_in;
      f_ff        <= f_in;
      p_ff        <= p_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== sv/wdrc_compressor_checker.sv =====
// Port-level checker for the compressor and its bind to the top level.
`default_nettype none
`include "wdrc_compressor_top_macros.svh"
module wdrc_compressor_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input wdrc_pkg::rsp_data_type rsp_data
);
   import wdrc_pkg::*;

   // Samples taken but whose transaction on the response side has not completed.
   logic [1:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `WDRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")
   `WDRC_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")
   `WDRC_ASSERT_NOW(a_rsp_has_req, rsp_valid, pend_ff != 2'd0, "response without a request")
   `WDRC_ASSERT_NOW(a_pend_bound, req_valid && req_ready, pend_ff <= 2'd1, "too many samples in flight")
   `WDRC_ASSERT_RESET(a_reset_idle, reset, !rsp_valid && req_ready, "not idle after reset")

endmodule

bind wdrc_compressor_top wdrc_compressor_checker u_checker (.*);
`default_nettype wire
